// ----- rtl/ctsn_pkg.sv -----
// Shared types and constants for the count tree with range sum and nearest search.
// Used by ctsn_ctrl, ctsn_dpath and count_tree_sum_and_nearest. No dependencies.
package ctsn_pkg;

   // Default number of leaf counters. It must be a power of two.
   localparam int LEAVES_DEFAULT = 1024;

   // Command codes.
   localparam logic [1:0] CMD_ADD   = 2'd0;
   localparam logic [1:0] CMD_SUM   = 2'd1;
   localparam logic [1:0] CMD_LEFT  = 2'd2;
   localparam logic [1:0] CMD_RIGHT = 2'd3;

   // Request transaction.
   typedef struct packed {
      logic [1:0]         cmd;
      logic [9:0]         position;
      logic signed [15:0] delta;
      logic [10:0]        range_low;
      logic [10:0]        range_high;
   } req_type;

   // Response transaction.
   typedef struct packed {
      logic [31:0] range_total;
      logic [9:0]  found_position;
      logic        found;
   } rsp_type;

   // Controller states, one-hot.
   typedef enum logic [10:0] {
      ST_CLEAR   = 11'b000_0000_0001,
      ST_IDLE    = 11'b000_0000_0010,
      ST_ADD_RD  = 11'b000_0000_0100,
      ST_ADD_WR  = 11'b000_0000_1000,
      ST_SUM_RD  = 11'b000_0001_0000,
      ST_SUM_ACC = 11'b000_0010_0000,
      ST_UP_RD   = 11'b000_0100_0000,
      ST_UP_CHK  = 11'b000_1000_0000,
      ST_DN_RD   = 11'b001_0000_0000,
      ST_DN_CHK  = 11'b010_0000_0000,
      ST_DONE    = 11'b100_0000_0000
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic clr_step;
      logic add_rd;
      logic add_wr;
      logic sum_rd;
      logic sum_acc;
      logic up_rd;
      logic up_chk;
      logic dn_rd;
      logic dn_chk;
      logic mark_found;
      logic finish;
   } ctl_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic [1:0] new_cmd;
      logic       new_pos_ok;
      logic       k_is_root;
      logic       k_is_leaf;
      logic       sum_more;
      logic       sib_hit;
      logic       clr_last;
      logic       rsp_busy;
   } stat_type;

endpackage

// ----- rtl/ctsn_ctrl.sv -----
// Sequencing state machine for the count tree: one command at a time.
// Depends on ctsn_pkg; drives the datapath through ctl_type and reads stat_type.
module ctsn_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  ctsn_pkg::stat_type stat,
   output ctsn_pkg::ctl_type  ctl
);
   import ctsn_pkg::*;

   state_type state_ff;
   state_type state_in;

   // New requests are taken only between commands.
   assign req_stall = (state_ff != ST_IDLE);

   // Next state and datapath commands.
   always_comb begin
      state_in = state_ff;
      ctl      = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            ctl.clr_step = 1'b1;
            if (stat.clr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               ctl.load = 1'b1;
               unique case (stat.new_cmd)
                  CMD_ADD:  state_in = stat.new_pos_ok ? ST_ADD_RD : ST_DONE;
                  CMD_SUM:  state_in = ST_SUM_RD;
                  default:  state_in = stat.new_pos_ok ? ST_UP_RD : ST_DONE;
               endcase
            end
         end
         ST_ADD_RD: begin
            ctl.add_rd = 1'b1;
            state_in   = ST_ADD_WR;
         end
         ST_ADD_WR: begin
            ctl.add_wr = 1'b1;
            state_in   = stat.k_is_root ? ST_DONE : ST_ADD_RD;
         end
         ST_SUM_RD: begin
            ctl.sum_rd = 1'b1;
            state_in   = stat.sum_more ? ST_SUM_ACC : ST_DONE;
         end
         ST_SUM_ACC: begin
            ctl.sum_acc = 1'b1;
            state_in    = ST_SUM_RD;
         end
         ST_UP_RD: begin
            ctl.up_rd = 1'b1;
            state_in  = stat.k_is_root ? ST_DONE : ST_UP_CHK;
         end
         ST_UP_CHK: begin
            ctl.up_chk = 1'b1;
            state_in   = stat.sib_hit ? ST_DN_RD : ST_UP_RD;
         end
         ST_DN_RD: begin
            ctl.dn_rd = 1'b1;
            if (stat.k_is_leaf) begin
               ctl.mark_found = 1'b1;
               state_in       = ST_DONE;
            end else begin
               state_in = ST_DN_CHK;
            end
         end
         ST_DN_CHK: begin
            ctl.dn_chk = 1'b1;
            state_in   = ST_DN_RD;
         end
         ST_DONE: begin
            // Wait until the output register can take the result.
            if (!stat.rsp_busy) begin
               ctl.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State register; reset starts the clearing pass.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- rtl/ctsn_dpath.sv -----
// Datapath for the count tree: node memory, walk index, range bounds, accumulator
// and the response register. Depends on ctsn_pkg; controlled by ctsn_ctrl.
module ctsn_dpath #(
   parameter int LEAVES = ctsn_pkg::LEAVES_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  ctsn_pkg::req_type  req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output ctsn_pkg::rsp_type  rsp_data,
   input  ctsn_pkg::ctl_type  ctl,
   output ctsn_pkg::stat_type stat
);
   import ctsn_pkg::*;

   localparam int LVL   = $clog2(LEAVES);
   localparam int NW    = LVL + 1;
   localparam int SW    = NW + 1;
   localparam int DEPTH = 2 * LEAVES;

   // Node sums, one write and two read ports with registered read data.
   logic [31:0]   mem [DEPTH];
   logic [31:0]   rd_a_ff;
   logic [31:0]   rd_b_ff;
   logic [NW-1:0] addr_a;
   logic [NW-1:0] addr_b;
   logic          wr_en;
   logic [NW-1:0] wr_addr;
   logic [31:0]   wr_data;

   // Command registers and walk state.
   logic [1:0]         cmd_ff;
   logic signed [15:0] delta_ff;
   logic [NW-1:0]      k_ff;
   logic [NW-1:0]      k_in;
   logic [SW-1:0]      lo_ff;
   logic [SW-1:0]      lo_in;
   logic [SW-1:0]      hi_ff;
   logic [SW-1:0]      hi_in;
   logic [31:0]        acc_ff;
   logic [31:0]        acc_in;
   logic               found_ff;
   logic               found_in;
   logic [NW-1:0]      clr_ff;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   rsp_type            rsp_ff;
   rsp_type            rsp_in;

   // Request decoding.
   logic [31:0]   pos_wide;
   logic [31:0]   low_wide;
   logic [31:0]   high_wide;
   logic [31:0]   low_clamp;
   logic [31:0]   high_clamp;
   logic [NW-1:0] leaf_index;

   // Walk helpers.
   logic          toward_right;
   logic [SW-1:0] hi_dec;
   logic [SW-1:0] lo_inc;
   logic [31:0]   part_a;
   logic [31:0]   part_b;
   logic [NW-1:0] child_addr;
   logic          child_bit;
   logic [31:0]   delta_wide;

   assign toward_right = (cmd_ff == CMD_RIGHT);
   assign delta_wide   = {{16{delta_ff[15]}}, delta_ff};

   // Position check, leaf index and clamped range bounds of a new request.
   always_comb begin
      pos_wide   = 32'(req_data.position);
      low_wide   = 32'(req_data.range_low);
      high_wide  = 32'(req_data.range_high);
      low_clamp  = (low_wide > 32'(LEAVES)) ? 32'(LEAVES) : low_wide;
      high_clamp = (high_wide > 32'(LEAVES)) ? 32'(LEAVES) : high_wide;
      leaf_index = NW'(pos_wide + 32'(LEAVES));
   end

   // Range walk arithmetic: odd bounds contribute their node and move inwards.
   assign hi_dec = hi_ff - SW'(1);
   assign lo_inc = lo_ff + {{NW{1'b0}}, lo_ff[0]};
   assign part_a = lo_ff[0] ? rd_a_ff : 32'd0;
   assign part_b = hi_ff[0] ? rd_b_ff : 32'd0;

   // On the way down, the child nearest the start point is read first.
   assign child_addr = {k_ff[NW-2:0], ~toward_right};
   assign child_bit  = (rd_a_ff != 32'd0) ^ toward_right;

   // Memory port selection.
   always_comb begin
      priority if (ctl.add_rd) begin
         addr_a = k_ff;
      end else if (ctl.up_rd) begin
         addr_a = k_ff ^ NW'(1);
      end else if (ctl.dn_rd) begin
         addr_a = child_addr;
      end else if (ctl.sum_rd) begin
         addr_a = lo_ff[NW-1:0];
      end else begin
         addr_a = k_ff;
      end
      addr_b = hi_dec[NW-1:0];
      wr_en  = ctl.clr_step || ctl.add_wr;
      if (ctl.clr_step) begin
         wr_addr = clr_ff;
         wr_data = 32'd0;
      end else begin
         wr_addr = k_ff;
         wr_data = rd_a_ff + delta_wide;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem[addr_a];
      rd_b_ff <= mem[addr_b];
   end

   // Walk state updates.
   always_comb begin
      k_in     = k_ff;
      lo_in    = lo_ff;
      hi_in    = hi_ff;
      acc_in   = acc_ff;
      found_in = found_ff;
      if (ctl.load) begin
         k_in     = leaf_index;
         lo_in    = SW'(low_clamp + 32'(LEAVES));
         hi_in    = SW'(high_clamp + 32'(LEAVES));
         acc_in   = 32'd0;
         found_in = 1'b0;
      end
      if (ctl.add_wr) begin
         k_in = k_ff >> 1;
      end
      if (ctl.sum_acc) begin
         acc_in = acc_ff + part_a + part_b;
         lo_in  = lo_inc >> 1;
         hi_in  = (hi_ff - {{NW{1'b0}}, hi_ff[0]}) >> 1;
      end
      if (ctl.up_chk) begin
         k_in = stat.sib_hit ? (k_ff ^ NW'(1)) : (k_ff >> 1);
      end
      if (ctl.dn_chk) begin
         k_in = {k_ff[NW-2:0], child_bit};
      end
      if (ctl.mark_found) begin
         found_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         cmd_ff   <= req_data.cmd;
         delta_ff <= req_data.delta;
      end
      k_ff     <= k_in;
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      acc_ff   <= acc_in;
      found_ff <= found_in;
   end

   // Clearing pass counter, one node per cycle after reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (ctl.clr_step) begin
         clr_ff <= clr_ff + NW'(1);
      end
   end

   // Response register: holds a finished result until the receiver takes it.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      if (ctl.finish) begin
         rsp_valid_in          = 1'b1;
         rsp_in.range_total    = acc_ff;
         rsp_in.found          = found_ff;
         rsp_in.found_position = found_ff ? 10'(k_ff[LVL-1:0]) : 10'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Status towards the controller.
   always_comb begin
      stat.new_cmd    = req_data.cmd;
      stat.new_pos_ok = (pos_wide < 32'(LEAVES));
      stat.k_is_root  = (k_ff == NW'(1));
      stat.k_is_leaf  = k_ff[NW-1];
      stat.sum_more   = (lo_ff < hi_ff);
      stat.sib_hit    = (toward_right ? ~k_ff[0] : k_ff[0]) && (rd_a_ff != 32'd0);
      stat.clr_last   = &clr_ff;
      stat.rsp_busy   = rsp_valid_ff && rsp_stall;
   end

endmodule

// ----- rtl/count_tree_sum_and_nearest.sv -----
// Each tree level of an add, range sum or nearest search costs one memory read step and
// one evaluate step. One command is in work at a time; the next is accepted as soon as
// the previous result sits in the output register. After reset a clearing pass zeroes
// all 2*LEAVES nodes of the node memory, during which no transaction is accepted.
module count_tree_sum_and_nearest #(
   parameter int LEAVES = ctsn_pkg::LEAVES_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  ctsn_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output ctsn_pkg::rsp_type rsp_data
);
   import ctsn_pkg::*;

   ctl_type  ctl;
   stat_type stat;

   // Sequencer.
   ctsn_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .ctl       (ctl)
   );

   // Tree memory and arithmetic.
   ctsn_dpath #(
      .LEAVES (LEAVES)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .ctl       (ctl),
      .stat      (stat)
   );

   // An accepted transaction blocks the input until its result is out.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request accepted while a command was in work");

   // A finished command always lands in the output register.
   a_finish_loads: assert property (@(posedge clock) disable iff (reset)
      ctl.finish |=> rsp_valid)
      else $error("finished command did not produce a response");

   // The clearing pass and the memory update never compete for the write port.
   a_write_exclusive: assert property (@(posedge clock) disable iff (reset)
      $onehot0({ctl.clr_step, ctl.add_wr, ctl.load, ctl.finish}))
      else $error("conflicting datapath commands");

   // No request is taken while the memory is being cleared.
   a_clear_blocks: assert property (@(posedge clock) disable iff (reset)
      ctl.clr_step |-> req_stall)
      else $error("request port open during clearing pass");

endmodule

// ----- verif/count_tree_sum_and_nearest_tb.sv -----
// Self-checking testbench for count_tree_sum_and_nearest: a directed table, then random
// command streams, checked against a local model of the sum tree and its searches.
// Depends on ctsn_pkg and the count_tree_sum_and_nearest RTL only.
module count_tree_sum_and_nearest_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ctsn_pkg::*;

   localparam int          TREE_LEAVES  = LEAVES_DEFAULT;
   localparam int          RANDOM_ITEMS = 1800;
   localparam int          DRAIN_CYCLES = 120;
   localparam int unsigned CYCLE_LIMIT  = 600000;
   localparam int          FAIL_REPORTS = 10;

   // Receiver back-pressure patterns.
   typedef enum int {
      STALL_NONE,
      STALL_RANDOM,
      STALL_PERIODIC
   } stall_mode_type;

   // One row of the directed table; the response is typed in where fixed is set.
   typedef struct {
      req_type req;
      bit      fixed;
      rsp_type rsp;
   } stim_row_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   // Side information that travels with the transaction being offered.
   bit      row_fixed = 1'b0;
   rsp_type row_rsp = '0;

   logic [31:0]    tree_sums [2*TREE_LEAVES];
   rsp_type        pending_results [$];
   stim_row_type   directed_rows [$];
   int unsigned    cycle_count = 0;
   int             fail_count = 0;
   int             burst_left = 0;
   stall_mode_type stall_mode = STALL_NONE;
   int             mode_left = 0;
   int unsigned    cluster_base = 0;
   int unsigned    add_pos_hist [$];
   logic [15:0]    add_delta_hist [$];

   count_tree_sum_and_nearest u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // Clock with a 12 ns period.
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Adds a sign-extended delta to a leaf and to every ancestor up to the root.
   function automatic void tree_add(int unsigned pos, logic [15:0] delta);
      int unsigned k;
      k = pos + TREE_LEAVES;
      while (k != 0) begin
         tree_sums[k] += {{16{delta[15]}}, delta};
         k = k >> 1;
      end
   endfunction

   // Sum over the half-open range [lo, hi), bounds clamped to the tree size.
   function automatic logic [31:0] tree_range_total(int unsigned lo, int unsigned hi);
      logic [31:0] acc;
      int unsigned l;
      int unsigned h;
      acc = '0;
      l = (lo > TREE_LEAVES) ? TREE_LEAVES : lo;
      h = (hi > TREE_LEAVES) ? TREE_LEAVES : hi;
      if (l >= h) return '0;
      l += TREE_LEAVES;
      h += TREE_LEAVES;
      while (l < h) begin
         if (l & 1) begin
            acc += tree_sums[l];
            l++;
         end
         if (h & 1) begin
            h--;
            acc += tree_sums[h];
         end
         l = l >> 1;
         h = h >> 1;
      end
      return acc;
   endfunction

   // Climbs until a sibling on the wanted side has a nonzero sum, then descends
   // towards the start point, always preferring the nonzero child nearest to it.
   function automatic bit tree_nearest(int unsigned pos, bit toward_right,
                                       output logic [9:0] where);
      int unsigned k;
      bit          on_side;
      where = '0;
      if (pos >= TREE_LEAVES) return 1'b0;
      k = pos + TREE_LEAVES;
      while (k > 1) begin
         on_side = toward_right ? ((k & 1) == 0) : ((k & 1) == 1);
         if (on_side && tree_sums[k ^ 1] != 0) begin
            k = k ^ 1;
            while (k < TREE_LEAVES) begin
               if (toward_right)
                  k = (tree_sums[2*k] != 0) ? 2*k : 2*k + 1;
               else
                  k = (tree_sums[2*k + 1] != 0) ? 2*k + 1 : 2*k;
            end
            where = 10'(k - TREE_LEAVES);
            return 1'b1;
         end
         k = k >> 1;
      end
      return 1'b0;
   endfunction

   // Works out the response to one command and updates the local tree.
   function automatic rsp_type predict_response(req_type r);
      rsp_type     res;
      logic [9:0]  where;
      res = '0;
      case (r.cmd)
         CMD_ADD: begin
            tree_add(32'(r.position), r.delta);
         end
         CMD_SUM: begin
            res.range_total = tree_range_total(32'(r.range_low), 32'(r.range_high));
         end
         default: begin
            res.found = tree_nearest(32'(r.position), r.cmd == CMD_RIGHT, where);
            res.found_position = res.found ? where : '0;
         end
      endcase
      return res;
   endfunction

   task automatic note_failure(string msg);
      if (fail_count < FAIL_REPORTS) $display("mismatch at cycle %0d: %s", cycle_count, msg);
      fail_count++;
   endtask

   task automatic add_row(logic [1:0] cmd, int unsigned pos, logic [15:0] delta,
                          int unsigned lo, int unsigned hi, bit fixed,
                          logic [31:0] total, int unsigned fpos, bit fnd);
      stim_row_type row;
      row.req.cmd            = cmd;
      row.req.position       = 10'(pos);
      row.req.delta          = delta;
      row.req.range_low      = 11'(lo);
      row.req.range_high     = 11'(hi);
      row.fixed              = fixed;
      row.rsp.range_total    = total;
      row.rsp.found_position = 10'(fpos);
      row.rsp.found          = fnd;
      directed_rows.insert(directed_rows.size(), row);
   endtask

   // Random command: positions mostly gathered in a moving window so that adds,
   // sums and searches meet, with some adds that cancel an earlier one.
   function automatic req_type make_random_req();
      req_type     r;
      int unsigned sel;
      int unsigned idx;
      int unsigned a;
      int unsigned b;
      r.cmd        = 2'($urandom_range(0, 3));
      r.delta      = 16'($urandom);
      r.range_low  = 11'($urandom);
      r.range_high = 11'($urandom);
      if ($urandom_range(0, 99) == 0) cluster_base = $urandom_range(0, TREE_LEAVES - 32);
      if ($urandom_range(0, 9) < 4) r.cmd = CMD_ADD;

      sel = $urandom_range(0, 9);
      if (sel < 6)
         r.position = 10'(cluster_base + $urandom_range(0, 31));
      else if (sel < 9)
         r.position = 10'($urandom);
      else
         r.position = $urandom_range(0, 1) ? 10'd1023 : 10'd0;

      if (r.cmd == CMD_ADD) begin
         sel = $urandom_range(0, 19);
         if (sel < 12) begin
            r.delta = 16'(int'($urandom_range(0, 16)) - 8);
         end else if (sel < 15 && add_pos_hist.size() != 0) begin
            // Undo an earlier add, so that leaves and subtrees return to zero.
            idx = $urandom_range(0, add_pos_hist.size() - 1);
            r.position = 10'(add_pos_hist[idx]);
            r.delta = -add_delta_hist[idx];
         end else if (sel < 18) begin
            r.delta = 16'($urandom);
         end else begin
            r.delta = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
         end
         add_pos_hist.insert(add_pos_hist.size(), 32'(r.position));
         add_delta_hist.insert(add_delta_hist.size(), r.delta);
         if (add_pos_hist.size() > 64) begin
            void'(add_pos_hist.pop_front());
            void'(add_delta_hist.pop_front());
         end
      end else if (r.cmd == CMD_SUM) begin
         sel = $urandom_range(0, 9);
         if (sel < 5) begin
            a = cluster_base + $urandom_range(0, 40);
            b = cluster_base + $urandom_range(0, 40);
            r.range_low  = 11'((a < b) ? a : b);
            r.range_high = 11'((a < b) ? b : a);
         end else if (sel < 8) begin
            r.range_low  = 11'($urandom_range(0, TREE_LEAVES));
            r.range_high = 11'($urandom_range(0, TREE_LEAVES));
         end
      end
      return r;
   endfunction

   // Offers one transaction from a falling edge and returns at a falling edge after
   // it has been taken, inserting a gap between bursts.
   task automatic send_item(req_type r, bit fixed, rsp_type rsp);
      int gap;
      req_valid <= 1'b1;
      req_data  <= r;
      row_fixed <= fixed;
      row_rsp   <= rsp;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                                  : $urandom_range(0, 12);
         gap = $urandom_range(1, 8);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end else begin
         burst_left--;
      end
   endtask

   // Holds the sender off until every expected response has arrived.
   task automatic drain_results();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending_results.size() != 0) @(negedge clock);
   endtask

   // Receiver stall pattern, with a randomly chosen mode that is switched when its countdown runs out.
   always @(negedge clock) begin
      if (mode_left == 0) begin
         stall_mode <= stall_mode_type'($urandom_range(0, 2));
         mode_left  <= $urandom_range(40, 160);
      end else begin
         mode_left <= mode_left - 1;
      end
      case (stall_mode)
         STALL_NONE:   rsp_stall <= 1'b0;
         STALL_RANDOM: rsp_stall <= ($urandom_range(0, 2) == 0);
         default:      rsp_stall <= ((mode_left % 11) < 6);
      endcase
   end

   // Watchdog on the total run length.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // Predicts each accepted request and checks each accepted response against
   // the oldest prediction.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_results.size() == 0) begin
               note_failure($sformatf("response %h with none expected", rsp_data));
            end else begin
               want = pending_results.pop_front();
               if (rsp_data.range_total !== want.range_total)
                  note_failure($sformatf("range_total expected %h, got %h",
                                         want.range_total, rsp_data.range_total));
               if (rsp_data.found_position !== want.found_position)
                  note_failure($sformatf("found_position expected %0d, got %0d",
                                         want.found_position, rsp_data.found_position));
               if (rsp_data.found !== want.found)
                  note_failure($sformatf("found expected %b, got %b",
                                         want.found, rsp_data.found));
            end
         end
         if (req_valid && !req_stall) begin
            want = predict_response(req_data);
            if (row_fixed) want = row_rsp;
            pending_results.insert(pending_results.size(), want);
         end
      end
   end

   // Main sequence: reset, directed table, random stream, drain and verdict.
   initial begin
      for (int i = 0; i < 2*TREE_LEAVES; i++) tree_sums[i] = '0;

      // Empty tree straight after reset.
      add_row(CMD_SUM,   0,    16'h0000, 0,    1024, 1, 32'h0, 0, 0);
      add_row(CMD_LEFT,  1023, 16'h0000, 0,    0,    1, 32'h0, 0, 0);
      add_row(CMD_RIGHT, 0,    16'h0000, 0,    0,    1, 32'h0, 0, 0);
      // Extreme deltas at the extreme positions.
      add_row(CMD_ADD,   0,    16'h7FFF, 2047, 2047, 1, 32'h0, 0, 0);
      add_row(CMD_ADD,   1023, 16'h8000, 0,    0,    1, 32'h0, 0, 0);
      add_row(CMD_SUM,   0,    16'h0000, 0,    1024, 1, 32'hFFFF_FFFF, 0, 0);
      // Bounds clamped beyond the tree, and empty or inverted ranges.
      add_row(CMD_SUM,   0,    16'h0000, 2047, 2047, 1, 32'h0, 0, 0);
      add_row(CMD_SUM,   0,    16'h0000, 0,    2047, 1, 32'hFFFF_FFFF, 0, 0);
      add_row(CMD_SUM,   0,    16'h0000, 1024, 0,    1, 32'h0, 0, 0);
      add_row(CMD_SUM,   0,    16'h0000, 5,    5,    1, 32'h0, 0, 0);
      // Searches across the whole tree and off either end.
      add_row(CMD_RIGHT, 0,    16'h0000, 0,    0,    1, 32'h0, 1023, 1);
      add_row(CMD_LEFT,  1023, 16'h0000, 0,    0,    1, 32'h0, 0, 1);
      add_row(CMD_LEFT,  0,    16'h0000, 0,    0,    1, 32'h0, 0, 0);
      add_row(CMD_RIGHT, 1023, 16'h0000, 0,    0,    1, 32'h0, 0, 0);
      // A pair of leaves whose subtree sum cancels to zero is skipped by searches.
      add_row(CMD_ADD,   512,  16'h0001, 0,    0,    0, 32'h0, 0, 0);
      add_row(CMD_ADD,   513,  16'hFFFF, 0,    0,    0, 32'h0, 0, 0);
      add_row(CMD_RIGHT, 100,  16'h0000, 0,    0,    0, 32'h0, 0, 0);
      add_row(CMD_LEFT,  600,  16'h0000, 0,    0,    0, 32'h0, 0, 0);
      add_row(CMD_ADD,   0,    16'h8001, 0,    0,    0, 32'h0, 0, 0);
      add_row(CMD_LEFT,  1023, 16'h0000, 0,    0,    0, 32'h0, 0, 0);
      add_row(CMD_SUM,   0,    16'h0000, 512,  513,  0, 32'h0, 0, 0);
      add_row(CMD_SUM,   0,    16'h0000, 1,    1023, 0, 32'h0, 0, 0);
      // Alternating bit patterns in position and delta.
      add_row(CMD_ADD,   341,  16'h5555, 1365, 682,  0, 32'h0, 0, 0);
      add_row(CMD_ADD,   682,  16'hAAAA, 682,  1365, 0, 32'h0, 0, 0);
      add_row(CMD_RIGHT, 341,  16'h0000, 0,    0,    0, 32'h0, 0, 0);

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_rows[i])
         send_item(directed_rows[i].req, directed_rows[i].fixed, directed_rows[i].rsp);
      drain_results();

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == RANDOM_ITEMS / 2) drain_results();
         send_item(make_random_req(), 1'b0, '0);
      end

      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_results.size() != 0)
         note_failure($sformatf("%0d responses never arrived", pending_results.size()));

      if (fail_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
